// ----- sv/assert_macros.svh -----
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked at every rising clk edge, off while rst is high.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// ----- sv/ffba_pkg.sv -----
// Types and constants of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int ADDR_BITS   = 24;
  localparam int ALIGN_BYTES = 16;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] req_size;
    logic [ADDR_BITS-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] payload_address;
    status_t              status;
  } rsp_t;

  // One block table entry as kept in memory.
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] bytes;
    logic                 is_free;
  } entry_t;

endpackage

// ----- sv/first_fit_block_allocator.sv -----
// Top level of the block allocator with splitting; of the free blocks that fit, it takes the highest start.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Sequence: start -> S_SCAN over every table entry -> S_DRAIN -> S_FINISH, which
//   registers done; S_SPLIT follows with busy still high when a block is split.
// A new request is taken only in S_IDLE; the table scan reads one entry a cycle
//   from the block table memory, which has one write and one registered read port.
// Reset: rst (synchronous) clears used bits, heap top and control; heap_limit -> 1048576.
// done pulses for one cycle; the receiver cannot stall it.
module first_fit_block_allocator #(
  parameter int TABLE_ENTRIES   = 16,
  parameter int HEADER_BYTES    = 32,
  parameter int MIN_SPLIT_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ffba_pkg::req_t                 req,
  output logic                           done,
  output ffba_pkg::rsp_t                 result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffba_pkg::ADDR_BITS-1:0] cfg_data
);
  import ffba_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [ADDR_BITS-1:0] HDR       = ADDR_BITS'(HEADER_BYTES);
  localparam logic [ADDR_BITS-1:0] SPLIT_MIN = ADDR_BITS'(HEADER_BYTES + MIN_SPLIT_BYTES);
  localparam logic [ADDR_BITS:0]   ALIGN_M   = (ADDR_BITS+1)'(ALIGN_BYTES - 1);
  localparam logic [IW:0]          LAST_IDX  = (IW+1)'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH, S_SPLIT} state_t;

  state_t                  state;
  logic [ADDR_BITS-1:0]    heap_limit;
  logic [ADDR_BITS-1:0]    heap_top;
  logic [TABLE_ENTRIES-1:0] used;

  // Current request
  logic                    op_free;
  logic [ADDR_BITS-1:0]    op_size;
  logic [ADDR_BITS-1:0]    op_addr;

  // Scan pipeline
  logic [IW:0]             scan_idx;
  logic                    q_vld;
  logic [IW-1:0]           q_idx;
  entry_t                  q_entry;

  // Scan results
  logic                    best_vld;
  logic [IW-1:0]           best_idx;
  logic [ADDR_BITS-1:0]    best_start;
  logic [ADDR_BITS-1:0]    best_bytes;
  logic                    match_vld;
  logic [IW-1:0]           match_idx;
  entry_t                  match_entry;

  // Pending split write
  logic [IW-1:0]           split_slot;
  entry_t                  split_entry;

  // Block table memory
  entry_t                  mem [TABLE_ENTRIES];
  logic                    rd_en;
  logic                    we;
  logic [IW-1:0]           waddr;
  entry_t                  wdata;

  logic [ADDR_BITS:0]      need_sum;
  logic [ADDR_BITS:0]      need;
  logic                    fit;
  logic                    hit;
  logic [ADDR_BITS-1:0]    rest;
  logic                    split_ok;
  logic [ADDR_BITS+2:0]    grow_end;
  logic                    have_empty;
  logic [IW-1:0]           empty_slot;
  logic                    set_used;
  logic [IW-1:0]           set_idx;

  // Size rounded up to the alignment
  assign need_sum = {1'b0, op_size} + ALIGN_M;
  assign need     = need_sum & ~ALIGN_M;

  // Lowest unused slot
  always_comb begin
    have_empty = 1'b0;
    empty_slot = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        have_empty = 1'b1;
        empty_slot = IW'(i);
      end
    end
  end

  // Per-entry checks on the word read last cycle
  assign fit = q_vld && used[q_idx] && q_entry.is_free && ({1'b0, q_entry.bytes} >= need)
               && (!best_vld || q_entry.start > best_start);
  assign hit = q_vld && used[q_idx] && !match_vld && ((q_entry.start + HDR) == op_addr);

  assign rest     = best_bytes - need[ADDR_BITS-1:0];
  assign split_ok = best_vld && (rest >= SPLIT_MIN) && have_empty;
  assign grow_end = (ADDR_BITS+3)'(heap_top) + (ADDR_BITS+3)'(HEADER_BYTES)
                  + (ADDR_BITS+3)'(need);

  assign rd_en = (state == S_SCAN);

  // Table write port and used-bit update
  always_comb begin
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    set_used = 1'b0;
    set_idx  = '0;
    unique case (state)
      S_FINISH: begin
        if (!op_free) begin
          if (best_vld) begin
            we    = 1'b1;
            waddr = best_idx;
            wdata = '{start: best_start,
                      bytes: split_ok ? need[ADDR_BITS-1:0] : best_bytes,
                      is_free: 1'b0};
          end else if (have_empty && grow_end <= (ADDR_BITS+3)'(heap_limit)) begin
            we       = 1'b1;
            waddr    = empty_slot;
            wdata    = '{start: heap_top, bytes: need[ADDR_BITS-1:0], is_free: 1'b0};
            set_used = 1'b1;
            set_idx  = empty_slot;
          end
        end else if (op_addr != '0 && match_vld) begin
          we    = 1'b1;
          waddr = match_idx;
          wdata = '{start: match_entry.start, bytes: match_entry.bytes, is_free: 1'b1};
        end
      end
      S_SPLIT: begin
        we       = 1'b1;
        waddr    = split_slot;
        wdata    = split_entry;
        set_used = 1'b1;
        set_idx  = split_slot;
      end
      default: ;
    endcase
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      q_entry <= mem[scan_idx[IW-1:0]];
    end
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Control and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_limit <= ADDR_BITS'(1048576);
      heap_top   <= '0;
      used       <= '0;
      q_vld      <= 1'b0;
      done       <= 1'b0;
    end else begin
      done  <= 1'b0;
      q_vld <= rd_en;
      q_idx <= scan_idx[IW-1:0];
      if (set_used) begin
        used[set_idx] <= 1'b1;
      end
      if (fit) begin
        best_vld   <= 1'b1;
        best_idx   <= q_idx;
        best_start <= q_entry.start;
        best_bytes <= q_entry.bytes;
      end
      if (hit) begin
        match_vld   <= 1'b1;
        match_idx   <= q_idx;
        match_entry <= q_entry;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            heap_limit <= cfg_data;
          end
          if (start) begin
            op_free   <= req.req_type;
            op_size   <= req.req_size;
            op_addr   <= req.free_address;
            scan_idx  <= '0;
            best_vld  <= 1'b0;
            match_vld <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          done                   <= 1'b1;
          result.payload_address <= '0;
          result.status          <= ST_OK;
          state                  <= S_IDLE;
          if (!op_free) begin
            if (best_vld) begin
              result.payload_address <= best_start + HDR;
              if (split_ok) begin
                split_slot  <= empty_slot;
                split_entry <= '{start: best_start + HDR + need[ADDR_BITS-1:0],
                                 bytes: rest - HDR, is_free: 1'b1};
                state       <= S_SPLIT;
              end
            end else if (!have_empty) begin
              result.status <= ST_FULL;
            end else if (grow_end > (ADDR_BITS+3)'(heap_limit)) begin
              result.status <= ST_OOM;
            end else begin
              result.payload_address <= heap_top + HDR;
              heap_top               <= grow_end[ADDR_BITS-1:0];
            end
          end else if (op_addr != '0 && !match_vld) begin
            result.status <= ST_UNKNOWN;
          end
        end
        S_SPLIT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_IMPL(a_done_from_finish, done, $past(state) == S_FINISH, "done without finish")
  `ASSERT_IMPL(a_used_sticky, !$past(rst), (used & $past(used)) == $past(used), "used bit lost")
  `ASSERT_IMPL(a_top_with_done, !$past(rst) && heap_top != $past(heap_top), done,
               "heap top moved without a result")
  `ASSERT_IMPL(a_no_write_idle, state == S_IDLE || state == S_SCAN, !we, "write during scan")

endmodule
